>>> rtl/core/htwc_pkg.sv
// Package with shared types, constants and codes for the window capture block.
`timescale 1ns / 1ps

package htwc_pkg;

    // Default window and pre-trigger ring sizes.
    localparam int WINDOW_LEN_DEF = 50;
    localparam int PRE_LEN_DEF    = 10;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_ENTER_LEVEL    = 2'd0;
    localparam logic [1:0] CFG_EXIT_LEVEL     = 2'd1;
    localparam logic [1:0] CFG_ARM_WHEN_ABOVE = 2'd2;
    localparam logic [1:0] CFG_COOLDOWN_TIME  = 2'd3;

    localparam logic signed [15:0] ENTER_LEVEL_RST = 16'sd896;
    localparam logic signed [15:0] EXIT_LEVEL_RST  = 16'sd1152;
    localparam logic               ARM_ABOVE_RST   = 1'b0;
    localparam logic [15:0]        COOLDOWN_RST    = 16'd800;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic        [5:0]  slot_index;
        logic        [7:0]  event_number;
        logic               last_slot;
    } out_t;

    // One stored sample: the six axes.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } sample_t;

    typedef enum logic [2:0] {
        CMD_RING,
        CMD_ARM,
        CMD_APPEND,
        CMD_DROP,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        sample_t     smp;
        logic [7:0]  event_number;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_COPY_RD,
        BK_COPY_WR,
        BK_PAD,
        BK_EMIT_RD,
        BK_EMIT_OUT
    } back_state_t;

endpackage

>>> rtl/core/htwc_front.sv
// Front end: configuration registers, trigger classification and event bookkeeping.
`timescale 1ns / 1ps

module htwc_front
    import htwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  in_t         sample,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic signed [15:0] enter_level_reg;
    logic signed [15:0] exit_level_reg;
    logic               arm_above_reg;
    logic [15:0]        cooldown_reg;

    logic               capturing_reg, capturing_next;
    logic [31:0]        last_event_reg, last_event_next;
    logic [7:0]         event_count_reg, event_count_next;

    logic               accept;
    logic               arm_hit;
    logic               exit_hit;
    logic [31:0]        elapsed;
    sample_t            smp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_level_reg <= ENTER_LEVEL_RST;
            exit_level_reg  <= EXIT_LEVEL_RST;
            arm_above_reg   <= ARM_ABOVE_RST;
            cooldown_reg    <= COOLDOWN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENTER_LEVEL:    enter_level_reg <= cfg_data;
                CFG_EXIT_LEVEL:     exit_level_reg  <= cfg_data;
                CFG_ARM_WHEN_ABOVE: arm_above_reg   <= cfg_data[0];
                CFG_COOLDOWN_TIME:  cooldown_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign sample_ready = !q_full;
    assign accept       = sample_valid && sample_ready;

    assign smp = '{accel_x: sample.accel_x, accel_y: sample.accel_y,
                   accel_z: sample.accel_z, gyro_x: sample.gyro_x,
                   gyro_y: sample.gyro_y, gyro_z: sample.gyro_z};

    assign arm_hit  = arm_above_reg ? (sample.accel_y > enter_level_reg)
                                    : (sample.accel_y < enter_level_reg);
    assign exit_hit = arm_above_reg ? (sample.accel_y < exit_level_reg)
                                    : (sample.accel_y > exit_level_reg);
    assign elapsed  = sample.now_ms - last_event_reg;

    always_comb
    begin
        capturing_next   = capturing_reg;
        last_event_next  = last_event_reg;
        event_count_next = event_count_reg;
        q_push           = accept;
        q_cmd.smp        = smp;
        q_cmd.op         = CMD_RING;
        q_cmd.event_number = event_count_reg;
        if (!capturing_reg)
        begin
            if (arm_hit)
            begin
                q_cmd.op = CMD_ARM;
            end
        end
        else if (exit_hit)
        begin
            if (elapsed > {16'd0, cooldown_reg})
            begin
                q_cmd.op           = CMD_EMIT;
                q_cmd.event_number = event_count_reg + 8'd1;
            end
            else
            begin
                q_cmd.op = CMD_DROP;
            end
        end
        else
        begin
            q_cmd.op = CMD_APPEND;
        end
        if (accept)
        begin
            if (!capturing_reg)
            begin
                capturing_next = arm_hit;
            end
            else if (exit_hit)
            begin
                capturing_next = 1'b0;
                if (q_cmd.op == CMD_EMIT)
                begin
                    event_count_next = q_cmd.event_number;
                    last_event_next  = sample.now_ms;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg   <= 1'b0;
            last_event_reg  <= 32'd0;
            event_count_reg <= 8'd0;
        end
        else
        begin
            capturing_reg   <= capturing_next;
            last_event_reg  <= last_event_next;
            event_count_reg <= event_count_next;
        end
    end

endmodule

>>> rtl/core/htwc_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module htwc_queue
    import htwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/htwc_back.sv
// Back end: pre-trigger ring, window memory, copy, padding and window drain.
`timescale 1ns / 1ps

module htwc_back
    import htwc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int PRE_LEN    = PRE_LEN_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    localparam int WI     = $clog2(WINDOW_LEN);
    localparam int FW     = $clog2(WINDOW_LEN + 1);
    localparam int PI     = (PRE_LEN > 1) ? $clog2(PRE_LEN) : 1;
    localparam int N_COPY = (PRE_LEN < WINDOW_LEN) ? PRE_LEN : WINDOW_LEN;

    back_state_t   state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic [WI-1:0] slot_reg, slot_next;
    logic [PI-1:0] ring_ptr_reg, ring_ptr_next;
    logic [PI-1:0] rp_reg, rp_next;
    logic [PI-1:0] ring_ptr_inc, rp_inc;

    sample_t       window_mem [WINDOW_LEN];
    sample_t       ring_mem   [PRE_LEN];
    logic [PRE_LEN-1:0] ring_valid_reg;

    logic          win_we, win_re;
    logic [WI-1:0] win_waddr, win_raddr;
    sample_t       win_wdata;
    sample_t       win_rdata_reg;

    logic          ring_we, ring_re;
    sample_t       ring_rdata_reg;
    logic          ring_rvalid_reg;

    logic          room;

    assign ring_ptr_inc = (ring_ptr_reg == PI'(PRE_LEN - 1)) ? '0 : ring_ptr_reg + 1'b1;
    assign rp_inc       = (rp_reg == PI'(PRE_LEN - 1)) ? '0 : rp_reg + 1'b1;
    assign room         = (fill_reg < FW'(WINDOW_LEN));

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        ring_ptr_next = ring_ptr_reg;
        rp_next       = rp_reg;
        q_pop         = 1'b0;
        win_we        = 1'b0;
        win_waddr     = fill_reg[WI-1:0];
        win_wdata     = cmd_reg.smp;
        win_re        = 1'b0;
        win_raddr     = slot_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
                case (cmd_reg.op)
                    CMD_RING:
                    begin
                        ring_we       = 1'b1;
                        ring_ptr_next = ring_ptr_inc;
                    end
                    CMD_ARM:
                    begin
                        // The arming sample lands in the ring first, so the copy
                        // starts at the slot after it: the oldest entry.
                        ring_we       = 1'b1;
                        ring_ptr_next = ring_ptr_inc;
                        rp_next       = ring_ptr_inc;
                        cnt_next      = '0;
                        state_next    = BK_COPY_RD;
                    end
                    CMD_APPEND:
                    begin
                        if (room)
                        begin
                            win_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    CMD_DROP:
                    begin
                        fill_next = '0;
                    end
                    CMD_EMIT:
                    begin
                        state_next = BK_PAD;
                    end
                    default: ;
                endcase
            end
            BK_COPY_RD:
            begin
                ring_re    = 1'b1;
                state_next = BK_COPY_WR;
            end
            BK_COPY_WR:
            begin
                win_we    = 1'b1;
                win_waddr = cnt_reg[WI-1:0];
                win_wdata = ring_rvalid_reg ? ring_rdata_reg : '0;
                rp_next   = rp_inc;
                if (cnt_reg == FW'(N_COPY - 1))
                begin
                    fill_next  = FW'(N_COPY);
                    state_next = BK_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = BK_COPY_RD;
                end
            end
            BK_PAD:
            begin
                // The closing sample is appended and then repeated to fill the window.
                if (room)
                begin
                    win_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    slot_next  = '0;
                    state_next = BK_EMIT_RD;
                end
            end
            BK_EMIT_RD:
            begin
                win_re     = 1'b1;
                state_next = BK_EMIT_OUT;
            end
            BK_EMIT_OUT:
            begin
                if (result_ready)
                begin
                    if (slot_reg == WI'(WINDOW_LEN - 1))
                    begin
                        fill_next  = '0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = BK_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            slot_reg     <= '0;
            ring_ptr_reg <= '0;
            rp_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            slot_reg     <= slot_next;
            ring_ptr_reg <= ring_ptr_next;
            rp_reg       <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Window memory.
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            window_mem[win_waddr] <= win_wdata;
        end
        if (win_re)
        begin
            win_rdata_reg <= window_mem[win_raddr];
        end
    end

    // Pre-trigger ring; entries never written read back as zero samples.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_ptr_reg] <= cmd_reg.smp;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg  <= '0;
            ring_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ring_we)
            begin
                ring_valid_reg[ring_ptr_reg] <= 1'b1;
            end
            if (ring_re)
            begin
                ring_rvalid_reg <= ring_valid_reg[rp_reg];
            end
        end
    end

    assign result_valid        = (state_reg == BK_EMIT_OUT);
    assign result.out_accel_x  = win_rdata_reg.accel_x;
    assign result.out_accel_y  = win_rdata_reg.accel_y;
    assign result.out_accel_z  = win_rdata_reg.accel_z;
    assign result.out_gyro_x   = win_rdata_reg.gyro_x;
    assign result.out_gyro_y   = win_rdata_reg.gyro_y;
    assign result.out_gyro_z   = win_rdata_reg.gyro_z;
    assign result.slot_index   = 6'(slot_reg);
    assign result.event_number = cmd_reg.event_number;
    assign result.last_slot    = (slot_reg == WI'(WINDOW_LEN - 1));

    // The fill count never runs past the window.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW_LEN))
        else $error("window fill count exceeds window length");

    // Draining starts only after padding has filled every slot.
    a_full_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT_RD) |-> (fill_reg == FW'(WINDOW_LEN)))
        else $error("window drained before it was full");

    // The ring copy stays within the copied length.
    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_COPY_WR) |-> (cnt_reg < FW'(N_COPY)))
        else $error("ring copy ran past its length");

    // Taking the last slot empties the window and frees the back end.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.last_slot) |=>
            (state_reg == BK_IDLE && fill_reg == '0))
        else $error("window not cleared after last slot");

endmodule

>>> rtl/core/hysteresis_triggered_window_capture.sv
// Top level of the hysteresis triggered pre-trigger window capture block.
// Flow: after an event's closing item, the back end pads the window with that sample and
// then offers the results one slot at a time, each held until it is taken. The back end
// works through one command at a time; the queue takes new items while it is busy, until full.
// Reset: control registers clear, the ring and window memories do not; unwritten ring entries
// read as zero via valid bits, no clearing pass.
`timescale 1ns / 1ps

module hysteresis_triggered_window_capture
    import htwc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int PRE_LEN    = PRE_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  in_t         sample,
    output logic        result_valid,
    input  logic        result_ready,
    output out_t        result
);

    // The front end owns the thresholds, the capturing flag and the event
    // bookkeeping, so it can classify every item the moment it arrives. Each
    // item becomes one command for the back end.
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;

    // The queue lets new items come in while the back end is still copying
    // the ring or draining a window whose result is stalled downstream.
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    htwc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    htwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // The back end holds the ring and window memories. It works through one
    // command at a time: ring write, ring copy into the window, append,
    // discard, or pad and drain the whole window one item per result.
    htwc_back #(
        .WINDOW_LEN (WINDOW_LEN),
        .PRE_LEN    (PRE_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_head_valid),
        .q_cmd        (q_head_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
